// ===== hdl/fpa_pkg.sv =====
// Shared types, codes and arithmetic helpers of the frame-tagged pixel accumulator.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package fpa_pkg;

	// Request kinds carried on the slave tuser.
	localparam logic [1:0] OP_ADD   = 2'd0;
	localparam logic [1:0] OP_SWEEP = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;
	localparam logic [1:0] OP_NONE  = 2'd3;

	// Result status codes carried on the master tuser.
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_STALE = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] REG_WIDTH   = 2'd0;
	localparam logic [1:0] REG_HEIGHT  = 2'd1;
	localparam logic [1:0] REG_MAX_AGE = 2'd2;
	localparam logic [1:0] REG_FADEOUT = 2'd3;

	localparam int IN_TDATA_W  = 112;
	localparam int OUT_TDATA_W = 72;
	localparam int MAIN_W      = 128;
	localparam int STAMP_W     = 32;

	// 0.9 in Q0.15 and the rounding bias for the fade.
	localparam logic signed [31:0] FADE_COEF = 32'sd29491;
	localparam logic signed [31:0] FADE_BIAS = 32'sd16384;

	typedef enum logic [1:0] {
		ADR_PIX,
		ADR_PASS,
		ADR_SWEEP
	} addr_sel_t;

	typedef enum logic [1:0] {
		WR_CLEAR,
		WR_RESTAMP,
		WR_ADD,
		WR_SWEEP
	} wr_sel_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic      load_in;
		logic      set_newest;
		logic      pass_clr;
		logic      pass_inc;
		logic      sweep_clr;
		logic      sweep_inc;
		addr_sel_t addr_sel;
		logic      main_we;
		logic      stamp_we;
		wr_sel_t   wr_sel;
		logic      load_out;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [1:0] op;
		logic       in_area;
		logic       stale;
		logic       newer;
		logic       pass_last;
		logic       sweep_last;
		logic       sweep_empty;
		logic       out_free;
		logic       dim_write;
	} sts_t;

	// Saturating signed 16-bit add.
	function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [15:0] b);
		logic signed [16:0] s;
		s = $signed({a[15], a}) + $signed({b[15], b});
		if (s > 17'sd32767) begin
			return 16'h7fff;
		end else if (s < -17'sd32768) begin
			return 16'h8000;
		end
		return s[15:0];
	endfunction

	// Multiply by 0.9 with round half up; the floor shift keeps ties toward plus infinity.
	function automatic logic [15:0] fade(input logic [15:0] c);
		logic signed [31:0] p;
		p = 32'($signed(c)) * FADE_COEF + FADE_BIAS;
		return p[30:15];
	endfunction

endpackage

`default_nettype wire

// ===== hdl/fpa_ram.sv =====
// Generic single-port RAM with a registered read.
// Stand-alone; used for the pixel store and the timestamp store.
`default_nettype none

module fpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                             clk,
	input  wire logic                             we,
	input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] addr,
	input  wire logic [WIDTH-1:0]                 wdata,
	output logic      [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write first in the array, read the old contents into the output register.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

`default_nettype wire

// ===== hdl/fpa_datapath.sv =====
// Datapath: configuration registers, request register, pixel and stamp memories,
// pass and sweep counters, update arithmetic and the result register. Uses fpa_pkg, fpa_ram.
`default_nettype none

module fpa_datapath #(
	parameter int MAX_WIDTH  = 128,
	parameter int MAX_HEIGHT = 128
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [1:0]                      cfg_addr,
	input  wire logic [15:0]                     cfg_wdata,
	input  wire logic [fpa_pkg::IN_TDATA_W-1:0]  s_tdata,
	input  wire logic [1:0]                      s_tuser,
	input  wire fpa_pkg::cmd_t                   cmd,
	output fpa_pkg::sts_t                        sts,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output logic [fpa_pkg::OUT_TDATA_W-1:0]      m_tdata,
	output logic [1:0]                           m_tuser
);
	import fpa_pkg::*;

	localparam int NPIX = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW   = $clog2(NPIX > 1 ? NPIX : 2);

	// Configuration registers.
	logic [7:0]  width_q, height_q;
	logic [15:0] max_age_q, fadeout_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q   <= 8'd128;
			height_q  <= 8'd128;
			max_age_q <= 16'd3000;
			fadeout_q <= 16'd1000;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_WIDTH:   width_q   <= cfg_wdata[7:0];
				REG_HEIGHT:  height_q  <= cfg_wdata[7:0];
				REG_MAX_AGE: max_age_q <= cfg_wdata;
				REG_FADEOUT: fadeout_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Request register.
	logic [1:0]  op_q;
	logic [6:0]  x_q, y_q;
	logic [15:0] frame_q;
	logic [15:0] c_q [3];
	logic [31:0] now_q;

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q    <= s_tuser;
			x_q     <= s_tdata[6:0];
			y_q     <= s_tdata[13:7];
			frame_q <= s_tdata[29:14];
			c_q[0]  <= s_tdata[45:30];
			c_q[1]  <= s_tdata[61:46];
			c_q[2]  <= s_tdata[77:62];
			now_q   <= s_tdata[109:78];
		end
	end

	// Newest frame seen, minus one before any frame.
	logic signed [16:0] newest_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			newest_q <= -17'sd1;
		end else if (cmd.set_newest) begin
			newest_q <= $signed({1'b0, frame_q});
		end
	end

	// Active area, limited to the memory size.
	logic [7:0] eff_w, eff_h;
	assign eff_w = (32'(width_q) > MAX_WIDTH) ? 8'(MAX_WIDTH) : width_q;
	assign eff_h = (32'(height_q) > MAX_HEIGHT) ? 8'(MAX_HEIGHT) : height_q;

	// Full-memory pass counter and active-area sweep counters.
	logic [AW-1:0] pass_q;
	logic [7:0]    sx_q, sy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pass_q <= '0;
		end else if (cmd.pass_clr) begin
			pass_q <= '0;
		end else if (cmd.pass_inc) begin
			pass_q <= pass_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sx_q <= '0;
			sy_q <= '0;
		end else if (cmd.sweep_clr) begin
			sx_q <= '0;
			sy_q <= '0;
		end else if (cmd.sweep_inc) begin
			if (sx_q == eff_w - 8'd1) begin
				sx_q <= '0;
				sy_q <= sy_q + 8'd1;
			end else begin
				sx_q <= sx_q + 8'd1;
			end
		end
	end

	// Memory address selection.
	logic [AW-1:0] pix_addr, sweep_addr, mem_addr;
	assign pix_addr   = AW'(32'(y_q) * MAX_WIDTH + 32'(x_q));
	assign sweep_addr = AW'(32'(sy_q) * MAX_WIDTH + 32'(sx_q));

	always_comb begin
		case (cmd.addr_sel)
			ADR_PIX:   mem_addr = pix_addr;
			ADR_PASS:  mem_addr = pass_q;
			ADR_SWEEP: mem_addr = sweep_addr;
			default:   mem_addr = pix_addr;
		endcase
	end

	logic [MAIN_W-1:0]  main_rd, main_wd, add_word, swp_word;
	logic [STAMP_W-1:0] stamp_rd, stamp_wd, swp_stamp;

	fpa_ram #(.WIDTH(MAIN_W), .DEPTH(NPIX)) u_main_ram (
		.clk   (clk),
		.we    (cmd.main_we),
		.addr  (mem_addr),
		.wdata (main_wd),
		.rdata (main_rd)
	);

	fpa_ram #(.WIDTH(STAMP_W), .DEPTH(NPIX)) u_stamp_ram (
		.clk   (clk),
		.we    (cmd.stamp_we),
		.addr  (mem_addr),
		.wdata (stamp_wd),
		.rdata (stamp_rd)
	);

	// Fields of the stored pixel word.
	logic [15:0] pc [3];
	logic [15:0] sc [3];
	logic [15:0] pt, st;
	logic        any_neg;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			pc[k] = main_rd[16*k +: 16];
			sc[k] = main_rd[64 + 16*k +: 16];
		end
	end
	assign pt      = main_rd[63:48];
	assign st      = main_rd[127:112];
	assign any_neg = c_q[0][15] | c_q[1][15] | c_q[2][15];

	// Contribution update: add to the pixel, stash a negative sample, or replace.
	logic [15:0] addend [3];
	logic [15:0] sum [3];
	logic [15:0] npc [3];
	logic [15:0] nsc [3];
	logic [15:0] npt, nst;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			addend[k] = (pt == frame_q) ? pc[k] : sc[k];
			sum[k]    = sat_add(addend[k], c_q[k]);
			npc[k]    = pc[k];
			nsc[k]    = sc[k];
		end
		npt = pt;
		nst = st;
		if (pt == frame_q) begin
			for (int k = 0; k < 3; k++) npc[k] = sum[k];
		end else if (any_neg) begin
			if (st == frame_q) begin
				for (int k = 0; k < 3; k++) nsc[k] = sum[k];
			end else if (st < frame_q) begin
				nst = frame_q;
				for (int k = 0; k < 3; k++) nsc[k] = c_q[k];
			end
		end else begin
			npt = frame_q;
			if (newest_q == $signed({1'b0, st})) begin
				for (int k = 0; k < 3; k++) begin
					npc[k] = sum[k];
					nsc[k] = '0;
				end
			end else begin
				for (int k = 0; k < 3; k++) npc[k] = c_q[k];
			end
		end
		add_word = {nst, nsc[2], nsc[1], nsc[0], npt, npc[2], npc[1], npc[0]};
	end

	// Age sweep: fade older-frame pixels past the age limit, blank those past the fade span.
	logic [31:0] age;
	logic [16:0] blank_age;
	logic        aged;
	logic [15:0] fc [3];

	assign age       = now_q - stamp_rd;
	assign blank_age = {1'b0, max_age_q} + {1'b0, fadeout_q};
	assign aged      = (pt != 16'd0) && ($signed({1'b0, pt}) < newest_q)
		&& (age > {16'd0, max_age_q});

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			fc[k] = fade(pc[k]);
		end
		swp_word  = main_rd;
		swp_stamp = stamp_rd;
		if (aged) begin
			if (age > {15'd0, blank_age}) begin
				swp_word[47:0]  = '0;
				swp_word[63:48] = newest_q[15:0];
				swp_stamp       = now_q;
			end else begin
				swp_word[47:0] = {fc[2], fc[1], fc[0]};
			end
		end
	end

	// Write data selection.
	always_comb begin
		case (cmd.wr_sel)
			WR_CLEAR: begin
				main_wd  = '0;
				stamp_wd = '0;
			end
			WR_RESTAMP: begin
				main_wd  = main_rd;
				stamp_wd = now_q;
			end
			WR_ADD: begin
				main_wd  = add_word;
				stamp_wd = stamp_rd;
			end
			WR_SWEEP: begin
				main_wd  = swp_word;
				stamp_wd = swp_stamp;
			end
			default: begin
				main_wd  = '0;
				stamp_wd = '0;
			end
		endcase
	end

	// Result status and visibility of the pixel color.
	logic       in_area, stale, show;
	logic [1:0] res_status;

	assign in_area = ({1'b0, x_q} < eff_w) && ({1'b0, y_q} < eff_h);
	assign stale   = $signed({1'b0, frame_q}) < newest_q;
	assign show    = in_area && (op_q != OP_NONE);

	always_comb begin
		res_status = ST_OK;
		if ((op_q inside {OP_ADD, OP_READ}) && !in_area) begin
			res_status = ST_RANGE;
		end else if (op_q == OP_ADD && stale) begin
			res_status = ST_STALE;
		end
	end

	// Result register; a new result loads once the previous one is taken.
	logic        out_valid_q;
	logic [1:0]  out_status_q;
	logic [47:0] out_color_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	logic signed [16:0] out_newest_q;

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_status_q <= res_status;
			out_color_q  <= show ? main_rd[47:0] : 48'd0;
			out_newest_q <= newest_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {7'd0, out_newest_q, out_color_q};

	assign sts.op          = op_q;
	assign sts.in_area     = in_area;
	assign sts.stale       = stale;
	assign sts.newer       = $signed({1'b0, frame_q}) > newest_q;
	assign sts.pass_last   = (pass_q == AW'(NPIX - 1));
	assign sts.sweep_last  = (sx_q == eff_w - 8'd1) && (sy_q == eff_h - 8'd1);
	assign sts.sweep_empty = (eff_w == 8'd0) || (eff_h == 8'd0);
	assign sts.out_free    = !out_valid_q || m_tready;
	assign sts.dim_write   = cfg_we && (cfg_addr inside {REG_WIDTH, REG_HEIGHT});

endmodule

`default_nettype wire

// ===== hdl/fpa_ctrl.sv =====
// Controller state machine: sequences clearing, restamp passes, read-modify-write,
// age sweeps and result loading. Uses fpa_pkg; drives fpa_datapath by commands.
`default_nettype none

module fpa_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           s_tvalid,
	output logic                s_tready,
	input  wire fpa_pkg::sts_t  sts,
	output fpa_pkg::cmd_t       cmd
);
	import fpa_pkg::*;

	typedef enum logic [8:0] {
		S_CLEAR   = 9'b000000001,
		S_IDLE    = 9'b000000010,
		S_DEC     = 9'b000000100,
		S_RESTAMP = 9'b000001000,
		S_ARD     = 9'b000010000,
		S_AMOD    = 9'b000100000,
		S_SRD     = 9'b001000000,
		S_SMOD    = 9'b010000000,
		S_FOUT    = 9'b100000000
	} state_t;

	state_t state_q, state_d;
	logic   fetch_q, fetch_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			fetch_q <= 1'b0;
		end else begin
			state_q <= state_d;
			fetch_q <= fetch_d;
		end
	end

	assign s_tready = (state_q == S_IDLE) && !sts.dim_write;

	// Next state and commands. fetch_q marks the read cycle before the result.
	always_comb begin
		state_d = state_q;
		fetch_d = 1'b0;
		cmd     = '0;
		cmd.addr_sel = ADR_PIX;
		cmd.wr_sel   = WR_CLEAR;
		case (state_q)
			S_CLEAR: begin
				cmd.addr_sel = ADR_PASS;
				cmd.main_we  = 1'b1;
				cmd.stamp_we = 1'b1;
				if (sts.dim_write) begin
					cmd.pass_clr = 1'b1;
				end else if (sts.pass_last) begin
					cmd.pass_clr = 1'b1;
					state_d      = S_IDLE;
				end else begin
					cmd.pass_inc = 1'b1;
				end
			end
			S_IDLE: begin
				if (sts.dim_write) begin
					cmd.pass_clr = 1'b1;
					state_d      = S_CLEAR;
				end else if (s_tvalid) begin
					cmd.load_in = 1'b1;
					state_d     = S_DEC;
				end
			end
			S_DEC: begin
				case (sts.op)
					OP_ADD: begin
						if (!sts.in_area) begin
							state_d = S_FOUT;
						end else if (sts.stale) begin
							fetch_d = 1'b1;
							state_d = S_FOUT;
						end else if (sts.newer) begin
							cmd.set_newest = 1'b1;
							cmd.pass_clr   = 1'b1;
							state_d        = S_RESTAMP;
						end else begin
							state_d = S_ARD;
						end
					end
					OP_SWEEP: begin
						cmd.sweep_clr = 1'b1;
						if (sts.sweep_empty) begin
							fetch_d = 1'b1;
							state_d = S_FOUT;
						end else begin
							state_d = S_SRD;
						end
					end
					OP_READ: begin
						fetch_d = 1'b1;
						state_d = S_FOUT;
					end
					default: state_d = S_FOUT;
				endcase
			end
			S_RESTAMP: begin
				cmd.addr_sel = ADR_PASS;
				cmd.wr_sel   = WR_RESTAMP;
				cmd.stamp_we = 1'b1;
				if (sts.pass_last) begin
					cmd.pass_clr = 1'b1;
					state_d      = S_ARD;
				end else begin
					cmd.pass_inc = 1'b1;
				end
			end
			S_ARD: begin
				state_d = S_AMOD;
			end
			S_AMOD: begin
				cmd.wr_sel  = WR_ADD;
				cmd.main_we = 1'b1;
				fetch_d     = 1'b1;
				state_d     = S_FOUT;
			end
			S_SRD: begin
				cmd.addr_sel = ADR_SWEEP;
				state_d      = S_SMOD;
			end
			S_SMOD: begin
				cmd.addr_sel = ADR_SWEEP;
				cmd.wr_sel   = WR_SWEEP;
				cmd.main_we  = 1'b1;
				cmd.stamp_we = 1'b1;
				if (sts.sweep_last) begin
					fetch_d = 1'b1;
					state_d = S_FOUT;
				end else begin
					cmd.sweep_inc = 1'b1;
					state_d       = S_SRD;
				end
			end
			S_FOUT: begin
				// Pixel read data is valid in the cycle after the address settles.
				if (!fetch_q && sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

`default_nettype wire

// ===== hdl/frame_tagged_pixel_accumulator_top.sv =====
// Top level of the frame-tagged pixel accumulator.
// Depends on fpa_pkg, fpa_ram, fpa_datapath and fpa_ctrl.
//
// Usage: requests enter on the s_ stream (tuser = op: add, sweep, read) and each
// gives exactly one result on the m_ stream (tuser = status, tdata = pixel color
// after the operation and the newest frame number). Configuration is written
// through cfg_we / cfg_addr / cfg_wdata while no request is in flight.
// One request is worked on at a time; the pixel and stamp memories have a single
// port each, so a request goes through these steps from accept to result:
//   out-of-range add or unused op       no memory access, only the result,
//   read or stale add                   one pixel read before the result,
//   add within the current frame        read, modify-write, read back,
//   add of a newer frame                a restamp pass over the whole memory first,
//   age sweep                           a read and a write of each pixel of the active area.
// After reset, and after every write of the width or height, a clearing pass over
// the whole memory zeroes all pixels; s_tready stays low meanwhile.
// The result sits in an output register; a stalled receiver holds it and the
// block can accept the next request, which then waits for the register to free.
`default_nettype none

module frame_tagged_pixel_accumulator_top #(
	parameter int MAX_WIDTH  = 128,
	parameter int MAX_HEIGHT = 128
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// Configuration write port.
	input  wire logic                            cfg_we,
	input  wire logic [1:0]                      cfg_addr,
	input  wire logic [15:0]                     cfg_wdata,
	// Request stream.
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	// x[6:0], y[13:7], frame[29:14], red[45:30], green[61:46], blue[77:62], now_ms[109:78]
	input  wire logic [fpa_pkg::IN_TDATA_W-1:0]  s_tdata,
	// op[1:0]
	input  wire logic [1:0]                      s_tuser,
	// batch_end, informational only
	input  wire logic                            s_tlast,
	// Result stream.
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// out_red[15:0], out_green[31:16], out_blue[47:32], newest_frame[64:48]
	output logic [fpa_pkg::OUT_TDATA_W-1:0]      m_tdata,
	// status[1:0]
	output logic [1:0]                           m_tuser
);
	import fpa_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic s_ready;

	// Batch marks carry no meaning for the framebuffer.
	logic batch_end_unused;
	assign batch_end_unused = s_tlast;

	fpa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	fpa_datapath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cmd       (cmd),
		.sts       (sts),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	assign s_tready = s_ready & (batch_end_unused | ~batch_end_unused);

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking testbench of the frame-tagged pixel accumulator.
// Drives requests through the s_ stream, predicts each result and checks the m_ stream;
// depends on fpa_pkg and frame_tagged_pixel_accumulator_top.
`timescale 1ns / 100ps

module tb_top;
	import fpa_pkg::*;

	localparam int GRID_W = 128;
	localparam int GRID_H = 128;
	localparam int NPIX   = GRID_W * GRID_H;

	typedef struct {
		logic [1:0]         op;
		logic [6:0]         x;
		logic [6:0]         y;
		logic [15:0]        frame;
		logic signed [15:0] rgb [3];
		logic [31:0]        now;
		logic               last;
	} pixel_req_t;

	typedef struct {
		logic [1:0]         status;
		logic signed [15:0] rgb [3];
		logic signed [16:0] newest;
	} pixel_res_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_addr;
	logic [15:0] cfg_wdata;
	logic s_tvalid;
	logic s_tready;
	logic [IN_TDATA_W-1:0] s_tdata;
	logic [1:0] s_tuser;
	logic s_tlast;
	logic m_tvalid;
	logic m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic [1:0] m_tuser;

	frame_tagged_pixel_accumulator_top #(
		.MAX_WIDTH(GRID_W),
		.MAX_HEIGHT(GRID_H)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	// Predicted framebuffer state.
	logic signed [15:0] pix_rgb [NPIX][3];
	logic signed [15:0] stash_rgb [NPIX][3];
	logic [15:0] pix_tag [NPIX];
	logic [15:0] stash_tag [NPIX];
	logic [31:0] pix_stamp [NPIX];
	int newest_frame;
	int act_w;
	int act_h;
	logic [31:0] max_age;
	logic [31:0] fade_span;

	pixel_res_t pending_results[$];
	int send_idle_pct;
	int recv_idle_pct;
	int mismatches;
	int results_seen;
	int requests_sent;
	int frame_jumps;
	logic [31:0] clock_ms;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic logic signed [15:0] clamp16(input int v);
		if (v > 32767) begin
			return 16'sh7fff;
		end else if (v < -32768) begin
			return 16'sh8000;
		end
		return v[15:0];
	endfunction

	// Scale by 0.9 in Q0.15, rounding half toward plus infinity.
	function automatic logic signed [15:0] dim_by_tenth(input logic signed [15:0] c);
		longint p;
		p = longint'(c) * 29491 + 16384;
		return 16'(p >>> 15);
	endfunction

	task automatic clear_framebuffer();
		for (int i = 0; i < NPIX; i++) begin
			for (int k = 0; k < 3; k++) begin
				pix_rgb[i][k] = '0;
				stash_rgb[i][k] = '0;
			end
			pix_tag[i] = '0;
			stash_tag[i] = '0;
			pix_stamp[i] = '0;
		end
	endtask

	task automatic age_pixels(input logic [31:0] now);
		logic [31:0] blank_age;
		logic [31:0] age;
		int i;
		int t;
		blank_age = max_age + fade_span;
		for (int yy = 0; yy < act_h; yy++) begin
			for (int xx = 0; xx < act_w; xx++) begin
				i = yy * GRID_W + xx;
				t = int'(pix_tag[i]);
				age = now - pix_stamp[i];
				if (t > 0 && t < newest_frame && age > max_age) begin
					if (age > blank_age) begin
						pix_stamp[i] = now;
						pix_tag[i] = newest_frame[15:0];
						for (int k = 0; k < 3; k++) pix_rgb[i][k] = '0;
					end else begin
						for (int k = 0; k < 3; k++) pix_rgb[i][k] = dim_by_tenth(pix_rgb[i][k]);
					end
				end
			end
		end
	endtask

	function automatic logic [1:0] merge_sample(input int i, input int f, input int c[3],
			input logic [31:0] now);
		if (f < newest_frame) begin
			return ST_STALE;
		end
		if (f > newest_frame) begin
			newest_frame = f;
			for (int k = 0; k < NPIX; k++) pix_stamp[k] = now;
		end
		if (int'(pix_tag[i]) == f) begin
			for (int k = 0; k < 3; k++) pix_rgb[i][k] = clamp16(pix_rgb[i][k] + c[k]);
		end else if (c[0] < 0 || c[1] < 0 || c[2] < 0) begin
			// Negative samples of a frame not yet on the pixel wait in the stash.
			if (int'(stash_tag[i]) == f) begin
				for (int k = 0; k < 3; k++) stash_rgb[i][k] = clamp16(stash_rgb[i][k] + c[k]);
			end else if (int'(stash_tag[i]) < f) begin
				stash_tag[i] = f[15:0];
				for (int k = 0; k < 3; k++) stash_rgb[i][k] = c[k][15:0];
			end
		end else begin
			pix_tag[i] = f[15:0];
			if (newest_frame == int'(stash_tag[i])) begin
				for (int k = 0; k < 3; k++) begin
					pix_rgb[i][k] = clamp16(stash_rgb[i][k] + c[k]);
					stash_rgb[i][k] = '0;
				end
			end else begin
				for (int k = 0; k < 3; k++) pix_rgb[i][k] = c[k][15:0];
			end
		end
		return ST_OK;
	endfunction

	// Works out the result of one request and updates the predicted state.
	task automatic predict_pixel(input pixel_req_t q, output pixel_res_t e);
		logic in_area;
		logic show;
		int idx;
		int c[3];
		in_area = int'(q.x) < act_w && int'(q.y) < act_h;
		idx = in_area ? int'(q.y) * GRID_W + int'(q.x) : 0;
		show = 1'b0;
		e.status = ST_OK;
		for (int k = 0; k < 3; k++) c[k] = int'(q.rgb[k]);
		case (q.op)
			OP_ADD: begin
				if (!in_area) begin
					e.status = ST_RANGE;
				end else begin
					e.status = merge_sample(idx, int'(q.frame), c, q.now);
					show = 1'b1;
				end
			end
			OP_SWEEP: begin
				age_pixels(q.now);
				show = in_area;
			end
			OP_READ: begin
				if (!in_area) e.status = ST_RANGE;
				else show = 1'b1;
			end
			default: ;
		endcase
		for (int k = 0; k < 3; k++) e.rgb[k] = show ? pix_rgb[idx][k] : 16'sd0;
		e.newest = newest_frame[16:0];
	endtask

	// Sends one request, records its expected result, then maybe idles.
	task automatic send_request(input pixel_req_t q);
		pixel_res_t e;
		s_tdata = {2'b00, q.now, q.rgb[2], q.rgb[1], q.rgb[0], q.frame, q.y, q.x};
		s_tuser = q.op;
		s_tlast = q.last;
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		predict_pixel(q, e);
		pending_results.push_back(e);
		requests_sent++;
		@(negedge clk);
		s_tvalid = 1'b0;
		if ($urandom_range(99) < send_idle_pct) begin
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		while (pending_results.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		cfg_we = 1'b1;
		cfg_addr = idx;
		cfg_wdata = val;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			REG_WIDTH: begin
				act_w = val[7:0] > GRID_W ? GRID_W : int'(val[7:0]);
				clear_framebuffer();
			end
			REG_HEIGHT: begin
				act_h = val[7:0] > GRID_H ? GRID_H : int'(val[7:0]);
				clear_framebuffer();
			end
			REG_MAX_AGE: max_age = {16'd0, val};
			default: fade_span = {16'd0, val};
		endcase
		// A dimension write starts a clearing pass; wait for the block to take requests.
		repeat (3) @(negedge clk);
		while (!s_tready) @(negedge clk);
	endtask

	function automatic pixel_req_t make_req(input logic [1:0] op, input int x, input int y,
			input int f, input int r, input int g, input int b, input logic [31:0] now);
		pixel_req_t q;
		q.op = op;
		q.x = x[6:0];
		q.y = y[6:0];
		q.frame = f[15:0];
		q.rgb[0] = r[15:0];
		q.rgb[1] = g[15:0];
		q.rgb[2] = b[15:0];
		q.now = now;
		q.last = 1'b0;
		return q;
	endfunction

	function automatic logic signed [15:0] rand_channel(input logic neg);
		case ($urandom_range(9))
			0: return neg ? 16'sh8000 : 16'sh7fff;
			1: return 16'($urandom);
			default: return neg ? -16'($urandom_range(1, 6000)) : 16'($urandom_range(0, 6000));
		endcase
	endfunction

	// Mostly accumulation in the current frame on a small area, with stale,
	// out-of-range, newer-frame, sweep, read and unused-op requests mixed in.
	function automatic pixel_req_t rand_request();
		pixel_req_t q;
		int pick;
		int f;
		logic neg;
		pick = $urandom_range(99);
		q.op = pick < 62 ? OP_ADD : pick < 82 ? OP_READ : pick < 97 ? OP_SWEEP : OP_NONE;
		if ($urandom_range(9) == 0) begin
			q.x = 7'($urandom);
			q.y = 7'($urandom);
		end else begin
			q.x = 7'($urandom_range(act_w - 1));
			q.y = 7'($urandom_range(act_h - 1));
		end
		f = newest_frame < 0 ? 0 : newest_frame;
		pick = $urandom_range(99);
		if (pick < 3 && frame_jumps < 6 && f < 65000) begin
			f = f + $urandom_range(1, 3);
		end else if (pick < 12 && f > 0) begin
			f = $urandom_range(f - 1);
		end else if (pick < 15) begin
			f = $urandom;
		end
		if (q.op == OP_ADD && f > newest_frame) frame_jumps++;
		if (f > newest_frame && q.op != OP_ADD) f = newest_frame < 0 ? 0 : newest_frame;
		q.frame = f[15:0];
		neg = $urandom_range(2) == 0;
		for (int k = 0; k < 3; k++) q.rgb[k] = rand_channel(neg && ($urandom_range(1) == 0 || k == 2));
		clock_ms = clock_ms + $urandom_range(0, 40);
		if ($urandom_range(19) == 0) clock_ms = clock_ms + $urandom_range(0, 70000);
		q.now = clock_ms;
		q.last = $urandom_range(1);
		return q;
	endfunction

	task automatic run_random(input int count);
		frame_jumps = 0;
		for (int n = 0; n < count; n++) send_request(rand_request());
	endtask

	// Receiver stalls.
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Result checker.
	always @(posedge clk) begin
		pixel_res_t e;
		logic bad;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("ERROR: result with no request pending");
			end else begin
				e = pending_results.pop_front();
				bad = m_tuser != e.status || m_tdata[15:0] != e.rgb[0] ||
					m_tdata[31:16] != e.rgb[1] || m_tdata[47:32] != e.rgb[2] ||
					m_tdata[64:48] != e.newest;
				if (bad) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("ERROR: status %0d rgb %0d %0d %0d newest %0d, expected %0d rgb %0d %0d %0d newest %0d",
							m_tuser, $signed(m_tdata[15:0]), $signed(m_tdata[31:16]),
							$signed(m_tdata[47:32]), $signed(m_tdata[64:48]), e.status,
							e.rgb[0], e.rgb[1], e.rgb[2], e.newest);
					end
				end
			end
		end
	end

	// Reads before any frame, the unused op and a sweep with nothing to age.
	task automatic test_empty_buffer();
		send_request(make_req(OP_READ, 0, 0, 0, 0, 0, 0, 0));
		send_request(make_req(OP_READ, 127, 127, 0, 0, 0, 0, 0));
		send_request(make_req(OP_NONE, 5, 5, 65535, -1, -1, -1, 32'hffff_ffff));
		send_request(make_req(OP_SWEEP, 1, 1, 0, 0, 0, 0, 32'h0000_1000));
	endtask

	// Frame start, saturation, stash and replace, stale frame.
	task automatic test_accumulate();
		pixel_req_t q;
		send_request(make_req(OP_ADD, 127, 127, 0, 32767, 32767, 32767, 100));
		send_request(make_req(OP_ADD, 127, 127, 0, 32767, 1, 0, 110));
		send_request(make_req(OP_ADD, 0, 0, 0, -32768, -32768, -32768, 120));
		send_request(make_req(OP_ADD, 0, 0, 0, -32768, -5, 7, 130));
		send_request(make_req(OP_ADD, 3, 3, 1, 0, 0, 0, 200));
		send_request(make_req(OP_ADD, 4, 4, 1, -400, 200, 300, 210));
		send_request(make_req(OP_ADD, 4, 4, 1, 100, -32768, 5, 220));
		send_request(make_req(OP_ADD, 4, 4, 1, 32767, 32767, 100, 230));
		send_request(make_req(OP_ADD, 4, 4, 0, 9, 9, 9, 240));
		q = make_req(OP_READ, 4, 4, 0, 0, 0, 0, 250);
		q.last = 1'b1;
		send_request(q);
	endtask

	// Out-of-range coordinates, fading and blanking on a small area.
	task automatic test_fade_and_bounds();
		write_reg(REG_WIDTH, 16'd8);
		write_reg(REG_HEIGHT, 16'd4);
		write_reg(REG_MAX_AGE, 16'd10);
		write_reg(REG_FADEOUT, 16'd20);
		send_request(make_req(OP_READ, 8, 0, 1, 0, 0, 0, 300));
		send_request(make_req(OP_ADD, 0, 4, 1, 5, 5, 5, 300));
		send_request(make_req(OP_ADD, 2, 1, 2, 20000, -20000, 3, 300));
		send_request(make_req(OP_ADD, 2, 1, 2, 40, 4000, 7, 300));
		send_request(make_req(OP_ADD, 5, 3, 3, 1, 1, 1, 1000));
		send_request(make_req(OP_SWEEP, 2, 1, 3, 0, 0, 0, 1015));
		send_request(make_req(OP_SWEEP, 2, 1, 3, 0, 0, 0, 1025));
		send_request(make_req(OP_SWEEP, 2, 1, 3, 0, 0, 0, 1070));
		send_request(make_req(OP_SWEEP, 9, 9, 3, 0, 0, 0, 1200));
	endtask

	// Frame numbers up to the top of their range; everything older is then stale.
	task automatic test_frame_ceiling();
		send_request(make_req(OP_ADD, 1, 0, 32767, 1, 2, 3, clock_ms));
		send_request(make_req(OP_ADD, 0, 0, 65535, 1000, 2000, 3000, clock_ms + 5));
		send_request(make_req(OP_ADD, 0, 0, 65534, 1, 1, 1, clock_ms + 6));
		send_request(make_req(OP_SWEEP, 1, 0, 0, 0, 0, 0, clock_ms + 32'h8000_0000));
		send_request(make_req(OP_READ, 1, 0, 0, 0, 0, 0, clock_ms));
	endtask

	task automatic test_random_phases();
		write_reg(REG_WIDTH, 16'd8);
		write_reg(REG_HEIGHT, 16'd8);
		write_reg(REG_MAX_AGE, 16'd100);
		write_reg(REG_FADEOUT, 16'd200);
		send_idle_pct = 25;
		recv_idle_pct = 74;
		run_random(230);

		write_reg(REG_WIDTH, 16'd16);
		write_reg(REG_HEIGHT, 16'd2);
		write_reg(REG_MAX_AGE, 16'd0);
		write_reg(REG_FADEOUT, 16'd0);
		clock_ms = 32'hffff_f000;
		send_idle_pct = 74;
		recv_idle_pct = 25;
		run_random(230);

		write_reg(REG_WIDTH, 16'd1);
		write_reg(REG_HEIGHT, 16'd128);
		write_reg(REG_MAX_AGE, 16'd65535);
		write_reg(REG_FADEOUT, 16'd65535);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_random(120);
		write_reg(REG_WIDTH, 16'd128);
		write_reg(REG_HEIGHT, 16'd1);
		write_reg(REG_MAX_AGE, 16'd30);
		run_random(120);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = REG_WIDTH;
		cfg_wdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = OP_NONE;
		s_tlast = 1'b0;
		m_tready = 1'b0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		mismatches = 0;
		results_seen = 0;
		requests_sent = 0;
		clock_ms = 32'd5000;
		act_w = GRID_W;
		act_h = GRID_H;
		max_age = 32'd3000;
		fade_span = 32'd1000;
		newest_frame = -1;
		clear_framebuffer();
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		test_empty_buffer();
		test_accumulate();
		test_fade_and_bounds();
		test_random_phases();
		test_frame_ceiling();

		while (pending_results.size() != 0) @(negedge clk);
		repeat (200) @(negedge clk);
		$display("Covered %0d requests and %0d results: adds, stash merges, reads, sweeps,",
			requests_sent, results_seen);
		$display("out-of-range and stale requests over six area settings and three stall mixes.");
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// Run limit.
	initial begin
		#60_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
